>>> hw/rtl/lcd4_pkg.sv
// lcd4_pkg: shared types and constants for the 4-bit character LCD driver
// no dependencies; used by lcd4_word_gen and char_lcd_4bit_shift_register_driver_unit

package lcd4_pkg;

    // operation codes of an input transaction
    typedef enum logic [1:0] {
        OP_CMD    = 2'd0,
        OP_DATA   = 2'd1,
        OP_CURSOR = 2'd2,
        OP_POWER  = 2'd3
    } lcd4_op_t;

    // shift register word bits
    localparam int unsigned EN_POS = 2;
    localparam int unsigned RS_POS = 0;

    // wait times in microseconds
    localparam logic [12:0] WAIT_EN_US      = 13'd1;
    localparam logic [12:0] WAIT_NIB_US     = 13'd50;
    localparam logic [12:0] WAIT_CLR_US     = 13'd2050;  // nibble wait plus clear/home
    localparam logic [12:0] WAIT_INIT1_US   = 13'd5050;  // first init nibble
    localparam logic [12:0] WAIT_INIT2_US   = 13'd200;   // second init nibble
    localparam logic [12:0] WAIT_INITCLR_US = 13'd4050;  // clear inside power-up
    localparam logic [15:0] WAIT_PWR_US     = 16'd40000;

    // command bytes
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] CMD_FUNC     = 8'h28;
    localparam logic [7:0] CMD_DISP     = 8'h0C;
    localparam logic [7:0] CMD_ENTRY    = 8'h06;
    localparam logic [3:0] NIB_INIT     = 4'h3;
    localparam logic [3:0] NIB_4BIT     = 4'h2;

    // step counts
    localparam logic [4:0] BYTE_LAST_STEP  = 5'd3;
    localparam logic [4:0] POWER_LAST_STEP = 5'd23;
    localparam logic [4:0] POWER_CMD_STEP  = 5'd8;

    // one generated result word
    typedef struct packed {
        logic [7:0]  word;
        logic [15:0] wait_before_us;
        logic [12:0] wait_after_us;
        logic        last;
    } lcd4_word_t;

endpackage

>>> hw/rtl/lcd4_word_gen.sv
// lcd4_word_gen: combinational word generator for one step of a transaction
// depends on lcd4_pkg

module lcd4_word_gen (
    input  lcd4_pkg::lcd4_op_t   op,
    input  logic [7:0]           cmd_byte,
    input  logic [4:0]           step,
    output lcd4_pkg::lcd4_word_t res
);
    import lcd4_pkg::*;

    logic       en;
    logic       rs;
    logic       is_clear;
    logic [3:0] nib;
    logic [3:0] pstep;
    logic [7:0] pcmd;

    // power-up command phase index
    assign pstep = step[3:0] - POWER_CMD_STEP[3:0];
    assign en    = ~step[0];

    // power-up command byte for this step
    always_comb
    begin
        unique case (pstep[3:2])
            2'd0: pcmd = CMD_FUNC;
            2'd1: pcmd = CMD_DISP;
            2'd2: pcmd = CMD_CLEAR;
            default: pcmd = CMD_ENTRY;
        endcase
    end

    assign is_clear = (op != OP_DATA) && ((cmd_byte == CMD_CLEAR) || (cmd_byte == CMD_HOME));

    // nibble, select, waits and the assembled shift register word
    always_comb
    begin
        rs                 = 1'b0;
        nib                = 4'h0;
        res.wait_before_us = 16'd0;
        res.wait_after_us  = en ? WAIT_EN_US : WAIT_NIB_US;
        res.last           = 1'b0;
        if (op == OP_POWER)
        begin
            if (step < POWER_CMD_STEP)
            begin
                nib = (step[2:1] == 2'd3) ? NIB_4BIT : NIB_INIT;
                if (step == 5'd0)
                    res.wait_before_us = WAIT_PWR_US;
                if (step == 5'd1)
                    res.wait_after_us = WAIT_INIT1_US;
                if (step == 5'd3)
                    res.wait_after_us = WAIT_INIT2_US;
            end
            else
            begin
                nib = pstep[1] ? pcmd[3:0] : pcmd[7:4];
                if (pstep == 4'd11)
                    res.wait_after_us = WAIT_INITCLR_US;
            end
            res.last = (step == POWER_LAST_STEP);
        end
        else
        begin
            rs  = (op == OP_DATA);
            nib = step[1] ? cmd_byte[3:0] : cmd_byte[7:4];
            if ((step[1:0] == 2'd3) && is_clear)
                res.wait_after_us = WAIT_CLR_US;
            res.last = (step == BYTE_LAST_STEP);
        end
        // assemble the shift register word
        res.word         = {nib, 4'h0};
        res.word[EN_POS] = en;
        res.word[RS_POS] = rs;
    end

endmodule

>>> hw/rtl/char_lcd_4bit_shift_register_driver_unit.sv
// char_lcd_4bit_shift_register_driver_unit: top level of the 4-bit LCD driver
// depends on lcd4_pkg and lcd4_word_gen
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid, in_stall | operation, value, row, col
//  out     | output    | out_valid, out_stall | word, wait_before_us, wait_after_us, last
//
// one result word leaves per cycle unless out_stall holds it: 4 words for a byte,
// cursor move or command, 24 for the power-up sequence; the step counter sets this.
// the next transaction is taken in the cycle its predecessor's last word loads.
// rst_n clears the busy flag, step counter and output valid.
// out_stall with a valid output holds the output register and freezes the step counter.

module char_lcd_4bit_shift_register_driver_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  value,
    input  logic        row,
    input  logic [5:0]  col,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  word,
    output logic [15:0] wait_before_us,
    output logic [12:0] wait_after_us,
    output logic        last
);
    import lcd4_pkg::*;

    logic       busy_reg, busy_next;
    logic [4:0] step_reg, step_next;
    lcd4_op_t   op_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg, out_valid_next;
    lcd4_word_t out_reg;
    lcd4_word_t gen;
    logic       advance;
    logic       done;
    logic       in_accept;
    lcd4_op_t   in_op;

    assign in_op = lcd4_op_t'(operation);

    // step generator
    lcd4_word_gen u_gen (
        .op       (op_reg),
        .cmd_byte (byte_reg),
        .step     (step_reg),
        .res      (gen)
    );

    // handshake control
    assign advance   = busy_reg && (!out_valid_reg || !out_stall);
    assign done      = advance && gen.last;
    assign in_stall  = busy_reg && !done;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (in_accept)
        begin
            busy_next = 1'b1;
            step_next = 5'd0;
        end
        else if (advance)
        begin
            step_next = step_reg + 5'd1;
            if (done)
                busy_next = 1'b0;
        end
        if (advance)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // transaction register: cursor move becomes its command byte
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg <= in_op;
            if (in_op == OP_CURSOR)
                byte_reg <= {1'b1, row, col};
            else
                byte_reg <= value;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= gen;
    end

    assign out_valid      = out_valid_reg;
    assign word           = out_reg.word;
    assign wait_before_us = out_reg.wait_before_us;
    assign wait_after_us  = out_reg.wait_after_us;
    assign last           = out_reg.last;

`ifndef NO_ASSERTIONS
    // step never runs past the power-up sequence
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg <= POWER_LAST_STEP))
        else $error("step counter out of range");

    // byte transactions use four steps only
    a_byte_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (op_reg != OP_POWER)) |-> (step_reg <= BYTE_LAST_STEP))
        else $error("byte transaction step out of range");

    // a new transaction always starts at the first step
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (busy_reg && (step_reg == 5'd0)))
        else $error("transaction did not start at step zero");

    // the power-up wait only comes with the first init word
    a_pwr_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (wait_before_us != 16'd0)) |-> (word == 8'h34))
        else $error("power-up wait on wrong word");

    // a loaded last word ends the transaction
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_accept) |=> !busy_reg)
        else $error("busy after last word");
`endif

endmodule
